### hw/rtl/usq_pkg.sv
// shared types and constants for the upload slot admission queue
`timescale 1ns / 1ps

package usq_pkg;

  localparam int ADDR_W = 32;
  localparam int SLOT_W = 8;
  localparam int POS_W  = 6;

  typedef logic [1:0] verdict_t;

  localparam verdict_t VERDICT_ADMIT  = 2'd0;
  localparam verdict_t VERDICT_REFUSE = 2'd1;
  localparam verdict_t VERDICT_WAIT   = 2'd2;

  // per-cell control from the queue sequencer
  typedef struct packed {
    logic shift;  // take the neighbor's address (pop at head)
    logic load;   // take the request address (append at tail)
  } cell_ctrl_t;

endpackage

### hw/rtl/upload_slot_admission_queue.sv
// top level of the upload slot admission queue
//
//   channel  signals                                          direction
//   in       in_valid/in_ready, host_addr, host_uploading,    request in
//            active_uploads
//   out      out_valid/out_ready, verdict, queue_position     result out
//   cfg      cfg_valid/cfg_ready, cfg_data (max_uploads)      register write
//
// a request passes through capture, parallel compare in the cell row, then
// priority pick and queue update before its result is valid.
// a new request is taken once the previous one has reached the output register.
// a stalled output holds the decision step; the queue updates only when the
// result is loaded. reset is synchronous: queue empty, max_uploads 4.
`timescale 1ns / 1ps

module upload_slot_admission_queue import usq_pkg::*; #(
  parameter int QUEUE_DEPTH = 32
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [ADDR_W-1:0] host_addr,
  input  logic              host_uploading,
  input  logic [SLOT_W-1:0] active_uploads,
  output logic              out_valid,
  input  logic              out_ready,
  output verdict_t          verdict,
  output logic [POS_W-1:0]  queue_position,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [SLOT_W-1:0] cfg_data
);

  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam int IW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_MATCH  = 2'd1;
  localparam logic [1:0] ST_DECIDE = 2'd2;

  logic [1:0]        state;
  logic [SLOT_W-1:0] max_uploads;
  logic [CW-1:0]     waiting_count;
  logic [ADDR_W-1:0] req_host;
  logic              req_busy;
  logic [SLOT_W-1:0] req_active;
  logic [QUEUE_DEPTH-1:0] hits;

  logic [ADDR_W-1:0] cell_addr [QUEUE_DEPTH];
  logic [QUEUE_DEPTH-1:0] cell_match;
  cell_ctrl_t        cell_ctrl [QUEUE_DEPTH];

  logic              hit;
  logic [IW-1:0]     first_idx;
  logic              out_free;
  logic              do_push;
  logic              do_pop;
  verdict_t          verdict_next;
  logic [POS_W-1:0]  position_next;
  logic [CW-1:0]     count_inc;

  assign in_ready  = (state == ST_IDLE);
  assign cfg_ready = 1'b1;
  assign out_free  = !out_valid || out_ready;
  assign count_inc = waiting_count + CW'(1);

  // config register
  always_ff @(posedge clk) begin
    if (rst) begin
      max_uploads <= SLOT_W'(4);
    end else if (cfg_valid && cfg_ready) begin
      max_uploads <= cfg_data;
    end
  end

  // request capture
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      req_host   <= host_addr;
      req_busy   <= host_uploading;
      req_active <= active_uploads;
    end
  end

  // row of cells, each shifting toward the head on pop
  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    logic [ADDR_W-1:0] shift_src;

    if (i == QUEUE_DEPTH - 1) begin : g_tail
      assign shift_src = '0;
    end else begin : g_mid
      assign shift_src = cell_addr[i+1];
    end

    assign cell_ctrl[i].shift = do_pop;
    assign cell_ctrl[i].load  = do_push && (waiting_count == CW'(i));

    usq_cell u_cell (
      .clk      (clk),
      .ctrl     (cell_ctrl[i]),
      .occupied (CW'(i) < waiting_count),
      .host     (req_host),
      .shift_in (shift_src),
      .addr     (cell_addr[i]),
      .match    (cell_match[i])
    );
  end

  // registered match vector
  always_ff @(posedge clk) begin
    if (state == ST_MATCH) begin
      hits <= cell_match;
    end
  end

  // first match from the head
  always_comb begin
    hit       = |hits;
    first_idx = '0;
    for (int i = QUEUE_DEPTH - 1; i >= 0; i--) begin
      if (hits[i]) begin
        first_idx = IW'(i);
      end
    end
  end

  // decision and queue action
  always_comb begin
    verdict_next  = VERDICT_ADMIT;
    position_next = '0;
    do_push       = 1'b0;
    do_pop        = 1'b0;
    if (req_busy) begin
      verdict_next = VERDICT_REFUSE;
    end else if (req_active < max_uploads) begin
      verdict_next = VERDICT_ADMIT;
    end else if (!hit) begin
      if (waiting_count == CW'(QUEUE_DEPTH)) begin
        verdict_next = VERDICT_REFUSE;
      end else begin
        verdict_next  = VERDICT_WAIT;
        position_next = POS_W'(count_inc);
        do_push       = (state == ST_DECIDE) && out_free;
      end
    end else if (first_idx == '0) begin
      verdict_next = VERDICT_ADMIT;
      do_pop       = (state == ST_DECIDE) && out_free;
    end else begin
      verdict_next  = VERDICT_WAIT;
      position_next = POS_W'(first_idx);
    end
  end

  // sequencer and queue length
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      waiting_count <= '0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (in_valid) begin
            state <= ST_MATCH;
          end
        end
        ST_MATCH: begin
          state <= ST_DECIDE;
        end
        ST_DECIDE: begin
          if (out_free) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
      if (do_push) begin
        waiting_count <= count_inc;
      end else if (do_pop) begin
        waiting_count <= waiting_count - CW'(1);
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if ((state == ST_DECIDE) && out_free) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == ST_DECIDE) && out_free) begin
      verdict        <= verdict_next;
      queue_position <= position_next;
    end
  end

`ifndef SYNTHESIS
  // queue length stays within the cell row
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    waiting_count <= CW'(QUEUE_DEPTH))
    else $error("queue length beyond depth");

  // queue length moves only on a decision that loads a result
  a_count_change: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) && !$stable(waiting_count) |->
      $past(state) == ST_DECIDE && out_valid)
    else $error("queue length changed outside decision");

  // only a wait verdict carries a position
  a_position_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && verdict != VERDICT_WAIT |-> queue_position == '0)
    else $error("position reported without wait verdict");
`endif

endmodule

### hw/rtl/usq_cell.sv
// one queue cell: holds a waiting host address and compares it to the request
`timescale 1ns / 1ps

module usq_cell import usq_pkg::*; (
  input  logic              clk,
  input  cell_ctrl_t        ctrl,
  input  logic              occupied,
  input  logic [ADDR_W-1:0] host,
  input  logic [ADDR_W-1:0] shift_in,
  output logic [ADDR_W-1:0] addr,
  output logic              match
);

  // address storage, shifted toward the head on pop
  always_ff @(posedge clk) begin
    if (ctrl.shift) begin
      addr <= shift_in;
    end else if (ctrl.load) begin
      addr <= host;
    end
  end

  // compare only while this cell lies inside the queue
  assign match = occupied && (addr == host);

endmodule
